### rtl/rvab_pkg.sv
package rvab_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned MODE_W = 5;
   localparam int unsigned TAG_W = 5;

   // operation codes
   localparam logic [MODE_W-1:0] OP_ADD   = 5'd0;
   localparam logic [MODE_W-1:0] OP_SUB   = 5'd1;
   localparam logic [MODE_W-1:0] OP_AND   = 5'd2;
   localparam logic [MODE_W-1:0] OP_OR    = 5'd3;
   localparam logic [MODE_W-1:0] OP_XOR   = 5'd4;
   localparam logic [MODE_W-1:0] OP_SLL   = 5'd5;
   localparam logic [MODE_W-1:0] OP_SRL   = 5'd6;
   localparam logic [MODE_W-1:0] OP_SRA   = 5'd7;
   localparam logic [MODE_W-1:0] OP_SLT   = 5'd8;
   localparam logic [MODE_W-1:0] OP_SLTU  = 5'd9;
   localparam logic [MODE_W-1:0] OP_BEQ   = 5'd10;
   localparam logic [MODE_W-1:0] OP_BNE   = 5'd11;
   localparam logic [MODE_W-1:0] OP_BLT   = 5'd12;
   localparam logic [MODE_W-1:0] OP_BGE   = 5'd13;
   localparam logic [MODE_W-1:0] OP_BLTU  = 5'd14;
   localparam logic [MODE_W-1:0] OP_BGEU  = 5'd15;
   localparam logic [MODE_W-1:0] OP_JAL   = 5'd16;
   localparam logic [MODE_W-1:0] OP_JALR  = 5'd17;
   localparam logic [MODE_W-1:0] OP_AUIPC = 5'd18;
   localparam logic [MODE_W-1:0] OP_LUI   = 5'd19;

   localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;
   localparam logic [XLEN-1:0] JALR_MASK  = ~32'd1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [XLEN-1:0]   operand_a;
      logic              operand_a_ok;
      logic [XLEN-1:0]   operand_b;
      logic              operand_b_ok;
      logic [XLEN-1:0]   pc;
      logic              pc_ok;
      logic [XLEN-1:0]   branch_offset;
      logic              branch_offset_ok;
      logic [TAG_W-1:0]  tag;
      logic              tag_ok;
      logic              flush;
   } req_type;

   typedef struct packed {
      logic [XLEN-1:0]  result_value;
      logic             result_value_ok;
      logic [XLEN-1:0]  next_pc;
      logic             next_pc_ok;
      logic [TAG_W-1:0] tag_out;
      logic             tag_out_ok;
   } rsp_type;

endpackage

### rtl/rvab_exec.sv
module rvab_exec (
   input  rvab_pkg::req_type req,
   output rvab_pkg::rsp_type rsp
);

   logic [rvab_pkg::XLEN-1:0] a;
   logic [rvab_pkg::XLEN-1:0] b;
   logic [4:0]                sh;
   logic [rvab_pkg::XLEN-1:0] sum_ab;
   logic [rvab_pkg::XLEN-1:0] diff_ab;
   logic [rvab_pkg::XLEN-1:0] sra_ab;
   logic [rvab_pkg::XLEN-1:0] pc_link;
   logic [rvab_pkg::XLEN-1:0] pc_target;
   logic [rvab_pkg::XLEN-1:0] pc_plus_b;
   logic                      eq_ab;
   logic                      lt_s;
   logic                      lt_u;
   logic                      ab_ok;
   logic                      br_ok;
   logic                      take;
   logic                      ran;
   logic [rvab_pkg::XLEN-1:0] val;
   logic                      val_ok;
   logic [rvab_pkg::XLEN-1:0] npc;
   logic                      npc_ok;

   assign a         = req.operand_a;
   assign b         = req.operand_b;
   assign sh        = b[4:0];
   assign sum_ab    = a + b;
   assign diff_ab   = a - b;
   assign sra_ab    = $unsigned($signed(a) >>> sh);
   assign pc_link   = req.pc + rvab_pkg::INSN_BYTES;
   assign pc_target = req.pc + req.branch_offset;
   assign pc_plus_b = req.pc + b;
   assign eq_ab     = (a == b);
   assign lt_s      = ($signed(a) < $signed(b));
   assign lt_u      = (a < b);
   assign ab_ok     = req.operand_a_ok & req.operand_b_ok;
   assign br_ok     = ab_ok & req.pc_ok & req.branch_offset_ok;

   always_comb begin
      val    = '0;
      val_ok = 1'b0;
      npc    = '0;
      npc_ok = 1'b0;
      take   = 1'b0;
      unique case (req.mode)
         rvab_pkg::OP_ADD: begin
            val = sum_ab; val_ok = ab_ok;
         end
         rvab_pkg::OP_SUB: begin
            val = diff_ab; val_ok = ab_ok;
         end
         rvab_pkg::OP_AND: begin
            val = a & b; val_ok = ab_ok;
         end
         rvab_pkg::OP_OR: begin
            val = a | b; val_ok = ab_ok;
         end
         rvab_pkg::OP_XOR: begin
            val = a ^ b; val_ok = ab_ok;
         end
         rvab_pkg::OP_SLL: begin
            val = a << sh; val_ok = ab_ok;
         end
         rvab_pkg::OP_SRL: begin
            val = a >> sh; val_ok = ab_ok;
         end
         rvab_pkg::OP_SRA: begin
            val = sra_ab; val_ok = ab_ok;
         end
         rvab_pkg::OP_SLT: begin
            val = {{(rvab_pkg::XLEN-1){1'b0}}, lt_s}; val_ok = ab_ok;
         end
         rvab_pkg::OP_SLTU: begin
            val = {{(rvab_pkg::XLEN-1){1'b0}}, lt_u}; val_ok = ab_ok;
         end
         rvab_pkg::OP_BEQ: begin
            take = eq_ab; npc_ok = br_ok;
         end
         rvab_pkg::OP_BNE: begin
            take = ~eq_ab; npc_ok = br_ok;
         end
         rvab_pkg::OP_BLT: begin
            take = lt_s; npc_ok = br_ok;
         end
         rvab_pkg::OP_BGE: begin
            take = ~lt_s; npc_ok = br_ok;
         end
         rvab_pkg::OP_BLTU: begin
            take = lt_u; npc_ok = br_ok;
         end
         rvab_pkg::OP_BGEU: begin
            take = ~lt_u; npc_ok = br_ok;
         end
         rvab_pkg::OP_JAL: begin
            val    = pc_link;
            npc    = pc_target;
            val_ok = req.pc_ok & req.branch_offset_ok;
            npc_ok = val_ok;
         end
         rvab_pkg::OP_JALR: begin
            val    = pc_link;
            npc    = sum_ab & rvab_pkg::JALR_MASK;
            val_ok = req.pc_ok & ab_ok;
            npc_ok = val_ok;
         end
         rvab_pkg::OP_AUIPC: begin
            val = pc_plus_b; val_ok = req.pc_ok & req.operand_b_ok;
         end
         rvab_pkg::OP_LUI: begin
            val = b; val_ok = req.operand_b_ok;
         end
         default: begin
            val_ok = 1'b0;
         end
      endcase
      // conditional branches resolve to target or fall-through
      if (req.mode >= rvab_pkg::OP_BEQ && req.mode <= rvab_pkg::OP_BGEU) begin
         npc = take ? pc_target : pc_link;
      end
   end

   assign ran = ~req.flush & (val_ok | npc_ok);

   always_comb begin
      rsp.result_value_ok = ~req.flush & val_ok;
      rsp.result_value    = rsp.result_value_ok ? val : '0;
      rsp.next_pc_ok      = ~req.flush & npc_ok;
      rsp.next_pc         = rsp.next_pc_ok ? npc : '0;
      rsp.tag_out_ok      = ran & req.tag_ok;
      rsp.tag_out         = rsp.tag_out_ok ? req.tag : '0;
   end

endmodule

### rtl/rv32i_alu_branch_unit_top.sv
// rv32i integer alu and branch unit
// takes one issued instruction per beat on the req_ channel: operation code,
// two operands, pc and branch offset with their ready flags, reorder buffer
// tag and a flush flag. gives one beat on the rsp_ channel per request beat:
// result value, resolved next pc and echoed tag, each with its own ok flag
// (a field whose ok flag is low reads zero)
// structure: input register -> single-pass combinational execute -> result
// register. a request beat accepted into the input register is executed and
// moves into the result register once that register can load, that is when
// it is empty or rsp_stall is low
// throughput is one beat per cycle; both registers move together when the
// result side is not stalled
// when rsp_stall is high the result register holds its beat; the input
// register still fills if empty, and req_stall rises only once both stages
// hold a beat, so no beat is lost or repeated
// synchronous active-high reset empties both stages; payload is not reset
module rv32i_alu_branch_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_mode,
   input  logic [31:0] req_operand_a,
   input  logic        req_operand_a_ok,
   input  logic [31:0] req_operand_b,
   input  logic        req_operand_b_ok,
   input  logic [31:0] req_pc,
   input  logic        req_pc_ok,
   input  logic [31:0] req_branch_offset,
   input  logic        req_branch_offset_ok,
   input  logic [4:0]  req_tag,
   input  logic        req_tag_ok,
   input  logic        req_flush,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_value,
   output logic        rsp_result_value_ok,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_next_pc_ok,
   output logic [4:0]  rsp_tag_out,
   output logic        rsp_tag_out_ok
);

   // input stage
   logic              issue_valid_ff;
   logic              issue_valid_in;
   rvab_pkg::req_type issue_ff;
   rvab_pkg::req_type issue_in;

   // result stage
   logic              res_valid_ff;
   logic              res_valid_in;
   rvab_pkg::rsp_type res_ff;
   rvab_pkg::rsp_type res_in;

   rvab_pkg::req_type req_beat;
   rvab_pkg::rsp_type exec_rsp;

   logic res_load;
   logic issue_load;

   // pack the request ports into one beat
   always_comb begin
      req_beat.mode             = req_mode;
      req_beat.operand_a        = req_operand_a;
      req_beat.operand_a_ok     = req_operand_a_ok;
      req_beat.operand_b        = req_operand_b;
      req_beat.operand_b_ok     = req_operand_b_ok;
      req_beat.pc               = req_pc;
      req_beat.pc_ok            = req_pc_ok;
      req_beat.branch_offset    = req_branch_offset;
      req_beat.branch_offset_ok = req_branch_offset_ok;
      req_beat.tag              = req_tag;
      req_beat.tag_ok           = req_tag_ok;
      req_beat.flush            = req_flush;
   end

   // result register takes a new beat when empty or being drained
   assign res_load   = ~res_valid_ff | ~rsp_stall;
   // input register takes a new beat when empty or passing its beat on
   assign issue_load = ~issue_valid_ff | res_load;
   assign req_stall  = ~issue_load;

   assign issue_valid_in = issue_load ? req_valid : issue_valid_ff;
   assign issue_in       = (issue_load && req_valid) ? req_beat : issue_ff;
   assign res_valid_in   = res_load ? issue_valid_ff : res_valid_ff;
   assign res_in         = (res_load && issue_valid_ff) ? exec_rsp : res_ff;

   rvab_exec u_exec (
      .req (issue_ff),
      .rsp (exec_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_valid_ff <= 1'b0;
         res_valid_ff   <= 1'b0;
      end else begin
         issue_valid_ff <= issue_valid_in;
         res_valid_ff   <= res_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      res_ff   <= res_in;
   end

   assign rsp_valid           = res_valid_ff;
   assign rsp_result_value    = res_ff.result_value;
   assign rsp_result_value_ok = res_ff.result_value_ok;
   assign rsp_next_pc         = res_ff.next_pc;
   assign rsp_next_pc_ok      = res_ff.next_pc_ok;
   assign rsp_tag_out         = res_ff.tag_out;
   assign rsp_tag_out_ok      = res_ff.tag_out_ok;

endmodule

### dv/rv32i_alu_branch_unit_top_test.sv
module rv32i_alu_branch_unit_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
   localparam int HOLD_CYCLES    = 80;    // long result-side hold-off
   localparam int TOTAL_ISSUES   = 1950;

   // ------------------------------------------------------------------
   // scoreboard: predicts each issued beat and checks results in order
   // ------------------------------------------------------------------
   class alu_scoreboard;
      rvab_pkg::rsp_type pending_results[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned suppressed;

      // predicted execute of one issued instruction
      function rvab_pkg::rsp_type execute_insn(rvab_pkg::req_type r);
         rvab_pkg::rsp_type o;
         logic [31:0] a, b;
         logic        ab_ok, taken;
         o = '0;
         taken = 1'b0;
         a = r.operand_a;
         b = r.operand_b;
         ab_ok = r.operand_a_ok & r.operand_b_ok;
         if (!r.flush) begin
            case (r.mode)
               rvab_pkg::OP_ADD, rvab_pkg::OP_SUB, rvab_pkg::OP_AND, rvab_pkg::OP_OR,
               rvab_pkg::OP_XOR, rvab_pkg::OP_SLL, rvab_pkg::OP_SRL, rvab_pkg::OP_SRA,
               rvab_pkg::OP_SLT, rvab_pkg::OP_SLTU: begin
                  if (ab_ok) begin
                     case (r.mode)
                        rvab_pkg::OP_ADD:  o.result_value = a + b;
                        rvab_pkg::OP_SUB:  o.result_value = a - b;
                        rvab_pkg::OP_AND:  o.result_value = a & b;
                        rvab_pkg::OP_OR:   o.result_value = a | b;
                        rvab_pkg::OP_XOR:  o.result_value = a ^ b;
                        rvab_pkg::OP_SLL:  o.result_value = a << b[4:0];
                        rvab_pkg::OP_SRL:  o.result_value = a >> b[4:0];
                        rvab_pkg::OP_SRA:  o.result_value = $signed(a) >>> b[4:0];
                        rvab_pkg::OP_SLT:
                           o.result_value = {31'b0, $signed(a) < $signed(b)};
                        default: o.result_value = {31'b0, a < b};
                     endcase
                     o.result_value_ok = 1'b1;
                  end
               end
               rvab_pkg::OP_BEQ, rvab_pkg::OP_BNE, rvab_pkg::OP_BLT, rvab_pkg::OP_BGE,
               rvab_pkg::OP_BLTU, rvab_pkg::OP_BGEU: begin
                  if (ab_ok && r.pc_ok && r.branch_offset_ok) begin
                     case (r.mode)
                        rvab_pkg::OP_BEQ:  taken = a == b;
                        rvab_pkg::OP_BNE:  taken = a != b;
                        rvab_pkg::OP_BLT:  taken = $signed(a) < $signed(b);
                        rvab_pkg::OP_BGE:  taken = $signed(a) >= $signed(b);
                        rvab_pkg::OP_BLTU: taken = a < b;
                        default: taken = a >= b;
                     endcase
                     o.next_pc = taken ? r.pc + r.branch_offset
                                       : r.pc + rvab_pkg::INSN_BYTES;
                     o.next_pc_ok = 1'b1;
                  end
               end
               rvab_pkg::OP_JAL: begin
                  if (r.pc_ok && r.branch_offset_ok) begin
                     o.result_value = r.pc + rvab_pkg::INSN_BYTES;
                     o.result_value_ok = 1'b1;
                     o.next_pc = r.pc + r.branch_offset;
                     o.next_pc_ok = 1'b1;
                  end
               end
               rvab_pkg::OP_JALR: begin
                  if (r.pc_ok && ab_ok) begin
                     o.result_value = r.pc + rvab_pkg::INSN_BYTES;
                     o.result_value_ok = 1'b1;
                     o.next_pc = (a + b) & rvab_pkg::JALR_MASK;
                     o.next_pc_ok = 1'b1;
                  end
               end
               rvab_pkg::OP_AUIPC: begin
                  if (r.pc_ok && r.operand_b_ok) begin
                     o.result_value = r.pc + b;
                     o.result_value_ok = 1'b1;
                  end
               end
               rvab_pkg::OP_LUI: begin
                  if (r.operand_b_ok) begin
                     o.result_value = b;
                     o.result_value_ok = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         // tag echoes only when the instruction actually executed
         if ((o.result_value_ok || o.next_pc_ok) && r.tag_ok) begin
            o.tag_out = r.tag;
            o.tag_out_ok = 1'b1;
         end
         return o;
      endfunction

      function void note_issue(rvab_pkg::req_type r);
         pending_results.push_back(execute_insn(r));
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rvab_pkg::rsp_type got);
         rvab_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing pending, expected none actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (!got.result_value_ok && !got.next_pc_ok && !got.tag_out_ok)
            suppressed++;
         compare_field("result_value", want.result_value, got.result_value);
         compare_field("result_value_ok", 32'(want.result_value_ok),
                       32'(got.result_value_ok));
         compare_field("next_pc", want.next_pc, got.next_pc);
         compare_field("next_pc_ok", 32'(want.next_pc_ok), 32'(got.next_pc_ok));
         compare_field("tag_out", 32'(want.tag_out), 32'(got.tag_out));
         compare_field("tag_out_ok", 32'(want.tag_out_ok), 32'(got.tag_out_ok));
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // clock, reset and the block
   // ------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [4:0]  req_mode = '0;
   logic [31:0] req_operand_a = '0;
   logic        req_operand_a_ok = 1'b0;
   logic [31:0] req_operand_b = '0;
   logic        req_operand_b_ok = 1'b0;
   logic [31:0] req_pc = '0;
   logic        req_pc_ok = 1'b0;
   logic [31:0] req_branch_offset = '0;
   logic        req_branch_offset_ok = 1'b0;
   logic [4:0]  req_tag = '0;
   logic        req_tag_ok = 1'b0;
   logic        req_flush = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_value;
   logic        rsp_result_value_ok;
   logic [31:0] rsp_next_pc;
   logic        rsp_next_pc_ok;
   logic [4:0]  rsp_tag_out;
   logic        rsp_tag_out_ok;

   always #5 clock = ~clock;

   rv32i_alu_branch_unit_top dut (.*);

   alu_scoreboard sb = new;

   // idle rates in percent, changed per phase by the main sequence
   int send_idle_pct = 37;
   int recv_idle_pct = 37;
   // hold-off requests go to the receiver process by a running count
   int holds_asked = 0;
   int holds_done  = 0;
   int hold_left   = 0;
   int issued      = 0;
   int idle_cycles = 0;

   logic [31:0] corner_vals [6] = '{32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff,
                                    32'h8000_0000, 32'hffff_ffff, 32'h0000_001f};

   // ------------------------------------------------------------------
   // result side: check each accepted beat, then pick next cycle's stall
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result('{rsp_result_value, rsp_result_value_ok, rsp_next_pc,
                              rsp_next_pc_ok, rsp_tag_out, rsp_tag_out_ok});
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            // long hold-off: both stages fill and the input side backs up
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog: any beat on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles, %0d results pending",
                  $time, idle_cycles, sb.pending());
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // one issue beat: random idle cycles first, then hold until accepted
   task automatic issue_insn(input rvab_pkg::req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_operand_a <= it.operand_a;
      req_operand_a_ok <= it.operand_a_ok;
      req_operand_b <= it.operand_b;
      req_operand_b_ok <= it.operand_b_ok;
      req_pc <= it.pc;
      req_pc_ok <= it.pc_ok;
      req_branch_offset <= it.branch_offset;
      req_branch_offset_ok <= it.branch_offset_ok;
      req_tag <= it.tag;
      req_tag_ok <= it.tag_ok;
      req_flush <= it.flush;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_issue(it);
      issued++;
   endtask

   // stop issuing and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic rvab_pkg::req_type ready_insn(logic [4:0] op, logic [31:0] a,
                                                    logic [31:0] b, logic [31:0] pc,
                                                    logic [31:0] off, logic [4:0] tag);
      rvab_pkg::req_type it;
      it = '{op, a, 1'b1, b, 1'b1, pc, 1'b1, off, 1'b1, tag, 1'b1, 1'b0};
      return it;
   endfunction

   // operand mix: mostly random, with small values and sign-boundary values
   function automatic logic [31:0] random_word();
      int sel;
      sel = $urandom_range(99);
      if (sel < 50) return $urandom;
      else if (sel < 65) return $urandom_range(40);
      else if (sel < 80) return corner_vals[$urandom_range(5)];
      else if (sel < 90) return 32'h8000_0000 + $urandom_range(8) - 4;
      else return -$urandom_range(40);
   endfunction

   // mostly well-formed issues; some flushes, missing flags and bad codes
   function automatic rvab_pkg::req_type random_insn();
      rvab_pkg::req_type it;
      if ($urandom_range(99) < 6)
         it.mode = 5'($urandom_range((1 << rvab_pkg::MODE_W) - 1, rvab_pkg::OP_LUI + 1));
      else
         it.mode = 5'($urandom_range(rvab_pkg::OP_LUI));
      it.operand_a = random_word();
      it.operand_b = ($urandom_range(99) < 15) ? it.operand_a : random_word();
      it.pc = random_word();
      it.branch_offset = random_word();
      it.tag = 5'($urandom_range((1 << rvab_pkg::TAG_W) - 1));
      it.operand_a_ok = $urandom_range(99) < 92;
      it.operand_b_ok = $urandom_range(99) < 92;
      it.pc_ok = $urandom_range(99) < 92;
      it.branch_offset_ok = $urandom_range(99) < 92;
      it.tag_ok = $urandom_range(99) < 90;
      it.flush = $urandom_range(99) < 4;
      return it;
   endfunction

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      rvab_pkg::req_type it;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every operation at operand extremes, tags counting down from 31
      for (int op = rvab_pkg::OP_ADD; op <= rvab_pkg::OP_LUI; op++)
         issue_insn(ready_insn(op[4:0], corner_vals[op % 6], corner_vals[(op + 2) % 6],
                               corner_vals[(op + 4) % 6], corner_vals[(op + 1) % 6],
                               5'(31 - op)));
      // flushed beat gives an all-invalid result
      it = ready_insn(rvab_pkg::OP_ADD, 32'hffff_ffff, 32'h1, 32'h100, 32'h8, 5'd3);
      it.flush = 1'b1;
      issue_insn(it);
      // first operand not ready
      it = ready_insn(rvab_pkg::OP_SUB, 32'h5, 32'h3, 32'h100, 32'h8, 5'd4);
      it.operand_a_ok = 1'b0;
      issue_insn(it);
      // undefined operation code
      it = ready_insn('1, 32'h5, 32'h3, 32'h100, 32'h8, 5'd5);
      issue_insn(it);
      // invalid tag: executes, tag not echoed
      it = ready_insn(rvab_pkg::OP_XOR, 32'haaaa_5555, 32'hffff_0000, 32'h100, 32'h8,
                      5'd6);
      it.tag_ok = 1'b0;
      issue_insn(it);
      // equal operands, taken branch with wraparound target
      it = ready_insn(rvab_pkg::OP_BEQ, 32'h1234, 32'h1234, 32'hffff_fffc, 32'h10, 5'd7);
      issue_insn(it);

      // random traffic with idling on both sides
      repeat (600) issue_insn(random_insn());

      // sender pauses until every result is back
      drain_results();

      // long result-side hold while the sender keeps offering beats
      send_idle_pct = 0;
      holds_asked = holds_asked + 1;
      repeat (200) issue_insn(random_insn());

      // full-rate stretch, no idling anywhere
      recv_idle_pct = 0;
      repeat (400) issue_insn(random_insn());
      drain_results();

      // back to random idling for the rest
      send_idle_pct = 37;
      recv_idle_pct = 37;
      while (issued < TOTAL_ISSUES)
         issue_insn(random_insn());
      drain_results();
      repeat (5) @(posedge clock);

      $display("run covered %0d issued beats: all operation codes, undefined codes,",
               issued);
      $display("flushes and missing ready flags; %0d results compared, %0d suppressed",
               sb.checked, sb.suppressed);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/rvab_pkg.sv
rtl/rvab_exec.sv
rtl/rv32i_alu_branch_unit_top.sv
dv/rv32i_alu_branch_unit_top_test.sv
